FILE: sv/kpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_pkg
// Types and constants shared by the key press classifier modules.
// ----------------------------------------------------------------------------
package kpc_pkg;

	localparam int unsigned KeyW      = 5;
	localparam int unsigned TimeW     = 12;
	localparam int unsigned AttrRegW  = 50;
	localparam int unsigned CfgIdxW   = 3;
	localparam int unsigned CfgDataW  = AttrRegW;
	localparam int unsigned AttrExtW  = 2 * (1 << KeyW);

	localparam logic [TimeW-1:0] HoldMax = {TimeW{1'b1}};

	localparam logic [TimeW-1:0]    ShortTimeRst   = 12'd5;
	localparam logic [TimeW-1:0]    RepFirstRst    = 12'd50;
	localparam logic [TimeW-1:0]    RepNextRst     = 12'd10;
	localparam logic [TimeW-1:0]    Long1TimeRst   = 12'd200;
	localparam logic [TimeW-1:0]    Long2TimeRst   = 12'd400;
	localparam logic [AttrRegW-1:0] KeyAttrRst     = '0;

	typedef enum logic [CfgIdxW-1:0] {
		REG_SHORT_TIME     = 3'd0,
		REG_REPEAT_FIRST   = 3'd1,
		REG_REPEAT_NEXT    = 3'd2,
		REG_LONG1_TIME     = 3'd3,
		REG_LONG2_TIME     = 3'd4,
		REG_KEY_ATTRIBUTES = 3'd5
	} kpc_reg_e;

	typedef enum logic [1:0] {
		ATTR_SHORT  = 2'd0,
		ATTR_REPEAT = 2'd1,
		ATTR_LONG1  = 2'd2,
		ATTR_LONG2  = 2'd3
	} kpc_attr_e;

	typedef enum logic [1:0] {
		PHASE_FIRST  = 2'd0,
		PHASE_SECOND = 2'd1,
		PHASE_NEXT   = 2'd2,
		PHASE_IDLE   = 2'd3
	} kpc_phase_e;

	typedef struct packed {
		logic            key_present;
		logic [KeyW-1:0] scan_key;
	} kpc_in_t;

	typedef struct packed {
		logic            event_valid;
		logic [KeyW-1:0] event_key;
		logic            long_flag;
	} kpc_out_t;

	typedef struct packed {
		logic [TimeW-1:0]    short_time;
		logic [TimeW-1:0]    repeat_first_time;
		logic [TimeW-1:0]    repeat_next_time;
		logic [TimeW-1:0]    long1_time;
		logic [TimeW-1:0]    long2_time;
		logic [AttrRegW-1:0] key_attributes;
	} kpc_cfg_t;

	typedef struct packed {
		logic             last_valid;
		logic [KeyW-1:0]  last_key;
		logic [TimeW-1:0] hold_ticks;
		kpc_phase_e       repeat_phase;
		logic             locked;
	} kpc_state_t;

endpackage

FILE: sv/kpc_classify.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kpc_classify
// Per-tick press classification: next tracking state and the event result.
// ----------------------------------------------------------------------------
module kpc_classify #(
	parameter int unsigned NUM_KEYS = 25
) (
	input  kpc_pkg::kpc_in_t    item,
	input  kpc_pkg::kpc_state_t cur,
	input  kpc_pkg::kpc_cfg_t   cfg,
	output kpc_pkg::kpc_state_t nxt,
	output kpc_pkg::kpc_out_t   result
);

	localparam int unsigned KeyCntW = kpc_pkg::KeyW + 1;

	logic [kpc_pkg::AttrExtW-1:0] attr_ext;
	logic [kpc_pkg::KeyW:0]       attr_pos;
	kpc_pkg::kpc_attr_e           attr;
	logic [kpc_pkg::TimeW-1:0]    rep_lim;
	logic [kpc_pkg::TimeW-1:0]    long_lim;
	logic [kpc_pkg::TimeW-1:0]    hold_mid;
	logic                         fire;
	logic                         is_long;

	// attribute of the held key; keys past the configured count act as short
	assign attr_ext = {{(kpc_pkg::AttrExtW - kpc_pkg::AttrRegW){1'b0}}, cfg.key_attributes};
	assign attr_pos = {cur.last_key, 1'b0};

	always_comb begin
		if ({1'b0, cur.last_key} < KeyCntW'(NUM_KEYS)) begin
			attr = kpc_pkg::kpc_attr_e'(attr_ext[attr_pos +: 2]);
		end else begin
			attr = kpc_pkg::ATTR_SHORT;
		end
	end

	always_comb begin
		unique case (cur.repeat_phase)
			kpc_pkg::PHASE_FIRST:  rep_lim = cfg.short_time;
			kpc_pkg::PHASE_SECOND: rep_lim = cfg.repeat_first_time;
			default:               rep_lim = cfg.repeat_next_time;
		endcase
	end

	assign long_lim = (attr == kpc_pkg::ATTR_LONG1) ? cfg.long1_time : cfg.long2_time;

	always_comb begin
		nxt      = cur;
		hold_mid = cur.hold_ticks;
		fire     = 1'b0;
		is_long  = 1'b0;
		if (item.key_present) begin
			if (!cur.last_valid || cur.last_key != item.scan_key) begin
				// new key: restart timing
				hold_mid         = '0;
				nxt.repeat_phase = kpc_pkg::PHASE_FIRST;
				nxt.locked       = 1'b0;
				nxt.last_key     = item.scan_key;
				nxt.last_valid   = 1'b1;
			end else if (!cur.locked) begin
				unique case (attr)
					kpc_pkg::ATTR_SHORT: begin
						if (cur.hold_ticks > cfg.short_time) begin
							fire       = 1'b1;
							nxt.locked = 1'b1;
						end
					end
					kpc_pkg::ATTR_REPEAT: begin
						if (cur.repeat_phase != kpc_pkg::PHASE_IDLE &&
						    cur.hold_ticks > rep_lim) begin
							fire     = 1'b1;
							hold_mid = '0;
							if (cur.repeat_phase == kpc_pkg::PHASE_FIRST) begin
								nxt.repeat_phase = kpc_pkg::PHASE_SECOND;
							end else begin
								nxt.repeat_phase = kpc_pkg::PHASE_NEXT;
							end
						end
					end
					default: begin
						if (cur.hold_ticks > long_lim) begin
							fire       = 1'b1;
							is_long    = 1'b1;
							nxt.locked = 1'b1;
						end
					end
				endcase
			end
			// count the held tick, saturating
			nxt.hold_ticks = (hold_mid != kpc_pkg::HoldMax) ? hold_mid + 1'b1 : hold_mid;
		end else begin
			// release: an early long key still reports a plain press
			if (cur.last_valid && !cur.locked &&
			    (attr == kpc_pkg::ATTR_LONG1 || attr == kpc_pkg::ATTR_LONG2) &&
			    cur.hold_ticks >= cfg.short_time) begin
				fire = 1'b1;
			end
			nxt.hold_ticks   = '0;
			nxt.repeat_phase = kpc_pkg::PHASE_FIRST;
			nxt.locked       = 1'b0;
			nxt.last_valid   = 1'b0;
			nxt.last_key     = '0;
		end
	end

	assign result.event_valid = fire;
	assign result.event_key   = fire ? cur.last_key : '0;
	assign result.long_flag   = is_long;

endmodule

FILE: sv/key_press_classifier_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_press_classifier_unit
// Short / repeat / long key press detector driven by one scan tick per beat.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall/in_data carry one scan tick per beat: whether a key is
//   pressed and its index. out_valid/out_stall/out_data return exactly one
//   result beat per input beat, in order: event_valid, event_key, long_flag.
//   Each accepted input beat reaches the output register through the input
//   register, then classify into the result register.
//   Throughput is one beat per cycle while the receiver does not stall; the
//   tracking state updates as each tick moves into the result register.
//   When the receiver stalls, the result register holds, the input register
//   holds one more beat, and in_stall rises once both are full.
//   cfg_we/cfg_index/cfg_data write the timing registers and the per-key
//   attribute word, and must be used only while no beat is in flight.
//   Reset empties both pipeline registers, the tracking state (no key held)
//   and loads the register defaults; the block accepts beats right after.
// ----------------------------------------------------------------------------
module key_press_classifier_unit #(
	parameter int unsigned NUM_KEYS = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kpc_pkg::kpc_in_t              in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kpc_pkg::kpc_out_t             out_data,
	input  logic                          cfg_we,
	input  logic [kpc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [kpc_pkg::CfgDataW-1:0]  cfg_data
);

	kpc_pkg::kpc_cfg_t   cfg_q;
	kpc_pkg::kpc_state_t state_q;
	kpc_pkg::kpc_state_t state_nxt;
	kpc_pkg::kpc_out_t   result;

	logic                valid_s1;
	kpc_pkg::kpc_in_t    data_s1;
	logic                valid_s2;
	kpc_pkg::kpc_out_t   data_s2;
	logic                adv_s2;
	logic                adv_s1;

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.short_time        <= kpc_pkg::ShortTimeRst;
			cfg_q.repeat_first_time <= kpc_pkg::RepFirstRst;
			cfg_q.repeat_next_time  <= kpc_pkg::RepNextRst;
			cfg_q.long1_time        <= kpc_pkg::Long1TimeRst;
			cfg_q.long2_time        <= kpc_pkg::Long2TimeRst;
			cfg_q.key_attributes    <= kpc_pkg::KeyAttrRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kpc_pkg::REG_SHORT_TIME:
					cfg_q.short_time <= cfg_data[kpc_pkg::TimeW-1:0];
				kpc_pkg::REG_REPEAT_FIRST:
					cfg_q.repeat_first_time <= cfg_data[kpc_pkg::TimeW-1:0];
				kpc_pkg::REG_REPEAT_NEXT:
					cfg_q.repeat_next_time <= cfg_data[kpc_pkg::TimeW-1:0];
				kpc_pkg::REG_LONG1_TIME:
					cfg_q.long1_time <= cfg_data[kpc_pkg::TimeW-1:0];
				kpc_pkg::REG_LONG2_TIME:
					cfg_q.long2_time <= cfg_data[kpc_pkg::TimeW-1:0];
				kpc_pkg::REG_KEY_ATTRIBUTES:
					cfg_q.key_attributes <= cfg_data[kpc_pkg::AttrRegW-1:0];
				default: begin
				end
			endcase
		end
	end

	// pipeline flow control
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			data_s1 <= in_data;
		end
	end

	kpc_classify #(
		.NUM_KEYS (NUM_KEYS)
	) u_classify (
		.item   (data_s1),
		.cur    (state_q),
		.cfg    (cfg_q),
		.nxt    (state_nxt),
		.result (result)
	);

	// tracking state moves only when the beat leaves the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.last_valid   <= 1'b0;
			state_q.last_key     <= '0;
			state_q.hold_ticks   <= '0;
			state_q.repeat_phase <= kpc_pkg::PHASE_FIRST;
			state_q.locked       <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			data_s2 <= result;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = data_s2;

endmodule
